// File: design/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants for the decimal square root
// Field widths, item structs, controller states and the fixed scale constants.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Field widths of the input and result items.
  localparam int INT_W      = 60;
  localparam int FRAC_W     = 54;
  localparam int ROOT_INT_W = 30;
  localparam int FRC_W      = 27;

  // Radicand in units of 1e-16, root in units of 1e-8.
  localparam int RAD_W  = INT_W + FRAC_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;

  // The unclamped root divided by 1e8 can exceed the result field by one bit.
  localparam int QUO_W = ROOT_INT_W + 1;

  // Place of the highest root digit.
  localparam int TOP_POWER = 8;
  localparam int TOP_EFF   = (TOP_POWER > 8) ? 8 : TOP_POWER;

  // Step counts of the two serial units.
  localparam int MUL_STEPS  = INT_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(MUL_STEPS);

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam logic [FRAC_W-1:0] IN_SCALE   = FRAC_W'(pow10(16));
  localparam logic [FRC_W-1:0]  ROOT_SCALE = FRC_W'(pow10(8));
  localparam logic [QUO_W-1:0]  SAT_QUO    = QUO_W'(pow10(TOP_EFF + 1));

  typedef struct packed {
    logic [INT_W-1:0]  value_integer;
    logic [FRAC_W-1:0] value_fraction;
    logic              is_negative;
  } in_item_t;

  typedef struct packed {
    logic [ROOT_INT_W-1:0] root_integer;
    logic [FRC_W-1:0]      root_fraction;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } dds_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEED,
    ST_ROOT,
    ST_DONE
  } dds_state_t;

endpackage

// File: design/decimal_digit_square_root.sv
// ----------------------------------------------------------------------------
// decimal_digit_square_root: truncated square root of a decimal fixed value
// One item at a time: a new item is accepted only once the previous one has
// left the controller, after the 60-step bit-serial multiply that forms the
// radicand and the 57-step one-bit root recurrence.
// Reset (rst, synchronous, active high) empties the output register and
// returns the controller to idle; datapath registers are not reset.
// ----------------------------------------------------------------------------
module decimal_digit_square_root import dds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  radicand,
  input  logic      radicand_valid,
  output logic      radicand_stall,
  output out_item_t root,
  output logic      root_valid,
  input  logic      root_stall
);

  // The decimal digit-by-digit method, with every digit capped at nine,
  // yields the integer square root of the radicand (in units of 1e-16) when
  // that root is below 10^(TOP_POWER+9), and all nines otherwise. The block
  // therefore computes the binary integer root and clamps it afterwards.

  dds_state_t       state;
  dds_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  dds_ctrl_t        mul_ctrl;
  dds_ctrl_t        root_ctrl;
  logic             load_out;
  logic             negative;

  logic [RAD_W-1:0] product;
  logic             root_bit;
  logic [QUO_W-1:0] quotient;
  logic [FRC_W-1:0] remainder;
  logic             saturate;
  out_item_t        result;

  // Radicand = value_integer * 10^16 + value_fraction, least significant
  // bit first.
  dds_mul u_mul (
    .clk        (clk),
    .ctrl       (mul_ctrl),
    .multiplier (radicand.value_integer),
    .addend     (radicand.value_fraction),
    .product    (product)
  );

  // Root bits leave the square root unit most significant first and go
  // straight into the divider, which needs them in that order.
  dds_sqrt u_sqrt (
    .clk      (clk),
    .ctrl     (root_ctrl),
    .radicand (product),
    .root_bit (root_bit)
  );

  dds_div u_div (
    .clk       (clk),
    .ctrl      (root_ctrl),
    .digit_in  (root_bit),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Controller: one item at a time. The radicand fields are sampled by the
  // multiplier on the accepting edge, so the input side needs no holding
  // register of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    mul_ctrl       = '0;
    root_ctrl      = '0;
    load_out       = 1'b0;
    radicand_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        radicand_stall = 1'b0;
        if (radicand_valid) begin
          mul_ctrl.load = 1'b1;
          cnt_next      = '0;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_SEED;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SEED: begin
        // The full product is now stable; hand it to the root unit.
        root_ctrl.load = 1'b1;
        state_next     = ST_ROOT;
      end
      ST_ROOT: begin
        root_ctrl.step = 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        // Wait only until the output register can take the result.
        if (!root_valid || !root_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_ctrl.load) begin
      negative <= radicand.is_negative;
    end
  end

  // A root of 10^(TOP_POWER+9) or more shows up as a quotient of
  // 10^(TOP_POWER+1) or more, since the limit is a multiple of 10^8. In that
  // case every decimal digit is nine. A negative radicand gives zero.
  assign saturate = quotient >= SAT_QUO;

  always_comb begin
    priority if (negative) begin
      result.root_integer  = '0;
      result.root_fraction = '0;
    end else if (saturate) begin
      result.root_integer  = ROOT_INT_W'(SAT_QUO - 1'b1);
      result.root_fraction = ROOT_SCALE - 1'b1;
    end else begin
      result.root_integer  = quotient[ROOT_INT_W-1:0];
      result.root_fraction = remainder;
    end
  end

  // Output register: holds a finished item while the receiver stalls, so
  // the next item can already be accepted and worked on.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (load_out) begin
      root_valid <= 1'b1;
    end else if (!root_stall) begin
      root_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      root <= result;
    end
  end

endmodule

// File: design/dds_mul.sv
// ----------------------------------------------------------------------------
// dds_mul: bit-serial multiply-add
// Forms value_integer * 10^16 + value_fraction, one multiplier bit per step.
// ----------------------------------------------------------------------------
module dds_mul import dds_pkg::*; (
  input  logic               clk,
  input  dds_ctrl_t          ctrl,
  input  logic [INT_W-1:0]   multiplier,
  input  logic [FRAC_W-1:0]  addend,
  output logic [RAD_W-1:0]   product
);

  // The accumulator starts with the addend; low product bits shift into the
  // places the multiplier bits vacate.
  logic [FRAC_W-1:0] acc;
  logic [INT_W-1:0]  low;
  logic [FRAC_W:0]   sum;

  assign sum = {1'b0, acc} + (low[0] ? {1'b0, IN_SCALE} : {(FRAC_W + 1){1'b0}});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= addend;
      low <= multiplier;
    end else if (ctrl.step) begin
      acc <= sum[FRAC_W:1];
      low <= {sum[0], low[INT_W-1:1]};
    end
  end

  assign product = {acc, low};

endmodule

// File: design/dds_sqrt.sv
// ----------------------------------------------------------------------------
// dds_sqrt: one-bit-per-step integer square root
// Shifts the radicand in two bits a step and emits root bits, MSB first.
// ----------------------------------------------------------------------------
module dds_sqrt import dds_pkg::*; (
  input  logic              clk,
  input  dds_ctrl_t         ctrl,
  input  logic [RAD_W-1:0]  radicand,
  output logic              root_bit
);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  partial;
  logic [ROOT_W-2:0] root;
  logic [REM_W+1:0]  cand;
  logic [REM_W-1:0]  trial;
  logic [REM_W+2:0]  diff;

  // The lowest root bit only arrives on the last step, so no trial needs it.
  assign cand     = {partial, rad[RAD_W-1 -: 2]};
  assign trial    = {root, 2'b01};
  assign diff     = {1'b0, cand} - {3'b000, trial};
  assign root_bit = ~diff[REM_W+2];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rad     <= radicand;
      partial <= '0;
      root    <= '0;
    end else if (ctrl.step) begin
      rad     <= {rad[RAD_W-3:0], 2'b00};
      partial <= root_bit ? diff[REM_W-1:0] : cand[REM_W-1:0];
      root    <= {root[ROOT_W-3:0], root_bit};
    end
  end

endmodule

// File: design/dds_div.sv
// ----------------------------------------------------------------------------
// dds_div: bit-serial division by 10^8
// Splits the serial root stream into integer and fraction parts.
// ----------------------------------------------------------------------------
module dds_div import dds_pkg::*; (
  input  logic              clk,
  input  dds_ctrl_t         ctrl,
  input  logic              digit_in,
  output logic [QUO_W-1:0]  quotient,
  output logic [FRC_W-1:0]  remainder
);

  logic [FRC_W-1:0] part;
  logic [QUO_W-1:0] quo;
  logic [FRC_W:0]   shifted;
  logic [FRC_W:0]   reduced;
  logic             fits;

  assign shifted = {part, digit_in};
  assign fits    = shifted >= {1'b0, ROOT_SCALE};
  assign reduced = shifted - {1'b0, ROOT_SCALE};

  // Every quotient bit is overwritten by the stream, so only the partial
  // remainder needs clearing.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      part <= '0;
    end else if (ctrl.step) begin
      part <= fits ? reduced[FRC_W-1:0] : shifted[FRC_W-1:0];
      quo  <= {quo[QUO_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = part;

endmodule
